/* src/mco_pkg.sv */
package mco_pkg;

	localparam int MAX_MATRICES = 16;
	localparam int DIM_DEPTH    = MAX_MATRICES + 1;
	localparam int STACK_DEPTH  = 2 * MAX_MATRICES + 2;
	localparam int CELL_DEPTH   = MAX_MATRICES * MAX_MATRICES;

	localparam int DIM_W  = 16;
	localparam int COST_W = 52;
	localparam int PROD_W = 3 * DIM_W;
	localparam int KIND_W = 3;

	// index width covers 0..MAX_MATRICES (dimension addresses run one past the last matrix)
	localparam int IW       = $clog2(DIM_DEPTH);
	localparam int CNT_W    = $clog2(DIM_DEPTH + 1);
	localparam int CELL_AW  = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
	localparam int STACK_AW = $clog2(STACK_DEPTH);
	localparam int SP_W     = $clog2(STACK_DEPTH + 1);

	localparam logic [COST_W-1:0] COST_MAX = '1;

	localparam logic [KIND_W-1:0] TOK_OPEN  = 3'd0;
	localparam logic [KIND_W-1:0] TOK_CLOSE = 3'd1;
	localparam logic [KIND_W-1:0] TOK_NAME  = 3'd2;
	localparam logic [KIND_W-1:0] TOK_COST  = 3'd3;
	localparam logic [KIND_W-1:0] TOK_ERROR = 3'd4;

	typedef struct packed {
		logic mul1;
		logic mul2;
		logic add;
	} mac_ctl_t;

	function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
		input logic [COST_W-1:0] b);
		logic [COST_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COST_W] ? COST_MAX : s[COST_W-1:0];
	endfunction

	function automatic logic [CELL_AW-1:0] cell_addr(input logic [IW-1:0] r,
		input logic [IW-1:0] c);
		return CELL_AW'(int'(r) * MAX_MATRICES + int'(c));
	endfunction

endpackage

/* src/mco_mac.sv */
// Shared multiply-add unit: one split candidate's cost over three steps.
module mco_mac (
	input  logic                         clk,
	input  mco_pkg::mac_ctl_t            ctl,
	input  logic [mco_pkg::DIM_W-1:0]    dim_i,
	input  logic [mco_pkg::DIM_W-1:0]    dim_k1,
	input  logic [mco_pkg::DIM_W-1:0]    dim_j1,
	input  logic [mco_pkg::COST_W-1:0]   cost_a,
	input  logic [mco_pkg::COST_W-1:0]   cost_b,
	output logic [mco_pkg::COST_W-1:0]   q
);
	import mco_pkg::*;

	logic [2*DIM_W-1:0] p1_q;
	logic [PROD_W-1:0]  prod_q;
	logic [COST_W-1:0]  sum_q;
	logic [COST_W-1:0]  q_q;

	always_ff @(posedge clk) begin
		if (ctl.mul1) begin
			p1_q  <= dim_i * dim_k1;
			sum_q <= sat_add(cost_a, cost_b);
		end
		if (ctl.mul2) begin
			prod_q <= p1_q * dim_j1;
		end
		if (ctl.add) begin
			q_q <= sat_add(sum_q, COST_W'(prod_q));
		end
	end

	assign q = q_q;

endmodule

/* src/matrix_chain_order_dp.sv */
// Channel  | Dir | Handshake            | Payload
// ---------+-----+----------------------+------------------------------------------
// dim      | in  | dim_valid / dim_stall | dimension[15:0], final_dim
// tok      | out | tok_valid / tok_stall | token_kind[2:0], token_value[51:0],
//          |     |                      | end_of_answer
//
// A dimension item that is not the last of its chain is taken and the block stays
// idle. The last item of a chain of two or more matrices starts the cost fill: per
// table cell the outer dimensions are read, then per split candidate the operands
// are read, multiplied and added in the one multiply-add unit, and compared. The walk
// then pushes the root, decodes each popped entry into a close, name or open item,
// pushes a close mark and both halves per open item, and ends with the cost item.
// dim_stall stays high from the last dimension until the final item of the
// answer is in the output register. A stalled output register holds the walk.
// Reset clears the sequencer, counters and output valid; the tables need no clear.
module matrix_chain_order_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          dim_valid,
	output logic                          dim_stall,
	input  logic [mco_pkg::DIM_W-1:0]     dimension,
	input  logic                          final_dim,
	output logic                          tok_valid,
	input  logic                          tok_stall,
	output logic [mco_pkg::KIND_W-1:0]    token_kind,
	output logic [mco_pkg::COST_W-1:0]    token_value,
	output logic                          end_of_answer
);
	import mco_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE, ST_ERR,
		ST_CELL_A, ST_CELL_B, ST_CELL_C,
		ST_K_RD, ST_K_MUL1, ST_K_MUL2, ST_K_ADD, ST_K_CMP,
		ST_W_ROOT, ST_W_POP, ST_W_DEC, ST_W_SPLIT, ST_W_PUSH2, ST_W_PUSH3, ST_W_COST
	} state_t;

	typedef struct packed {
		logic          close;
		logic [IW-1:0] lo;
		logic [IW-1:0] hi;
	} walk_ent_t;

	state_t state_q;

	// chain intake
	logic [CNT_W-1:0] dim_count_q;
	logic             ovf_q;
	logic [CNT_W-1:0] cnt_nx;
	logic             ovf_nx;
	logic [IW-1:0]    m_nx;
	logic             dim_accept;
	logic             dim_room;

	// fill loop indices
	logic [IW-1:0] m_q, len_q, i_q, k_q;
	logic [IW-1:0] j_w, j1_w;
	logic [DIM_W-1:0] dim_i_q, dim_j1_q;
	logic a_diag_q, b_diag_q;
	logic [COST_W-1:0] best_q, best_nx, mac_q;
	logic [IW-1:0]     bestk_q, bestk_nx;
	logic              take;

	// walk
	logic [SP_W-1:0] sp_q;
	logic [IW-1:0]   w_i_q, w_j_q;
	logic [IW-1:0]   name_q;
	logic            room;

	// output register
	logic              tok_valid_q;
	logic [KIND_W-1:0] kind_q;
	logic [COST_W-1:0] value_q;
	logic              end_q;
	logic              out_free;
	logic              tok_load;

	// memories
	logic [DIM_W-1:0]   dim_mem [DIM_DEPTH];
	logic [COST_W-1:0]  cost_mem [CELL_DEPTH];
	logic [IW-1:0]      split_mem [CELL_DEPTH];
	walk_ent_t          stack_mem [STACK_DEPTH];

	logic [IW-1:0]       dim_ra;
	logic [DIM_W-1:0]    dim_rd_q;
	logic [CELL_AW-1:0]  cost_ra_a, cost_ra_b, cell_wa, split_ra;
	logic [COST_W-1:0]   cost_rd_a_q, cost_rd_b_q;
	logic [IW-1:0]       split_rd_q;
	logic                cell_we;
	logic [STACK_AW-1:0] stack_ra;
	walk_ent_t           stack_rd_q;
	logic                stack_we;
	walk_ent_t           stack_wd;

	mac_ctl_t mac_ctl;

	assign dim_stall  = (state_q != ST_IDLE);
	assign dim_accept = dim_valid && !dim_stall;
	assign dim_room   = (dim_count_q < CNT_W'(DIM_DEPTH));
	assign cnt_nx     = dim_room ? dim_count_q + CNT_W'(1) : dim_count_q;
	assign ovf_nx     = ovf_q || !dim_room;
	assign m_nx       = IW'(cnt_nx - CNT_W'(1));

	assign j1_w = i_q + len_q;
	assign j_w  = j1_w - IW'(1);

	assign out_free = !tok_valid_q || !tok_stall;
	assign room     = (sp_q <= SP_W'(STACK_DEPTH - 3));
	// an item enters the output register this cycle
	assign tok_load = out_free &&
		((state_q == ST_ERR) || (state_q == ST_W_DEC) || (state_q == ST_W_COST));

	// keep the smallest split on ties: only a strictly cheaper candidate replaces
	assign take     = (k_q == i_q) || (mac_q < best_q);
	assign best_nx  = take ? mac_q : best_q;
	assign bestk_nx = take ? k_q : bestk_q;

	always_comb begin
		mac_ctl      = '0;
		mac_ctl.mul1 = (state_q == ST_K_MUL1);
		mac_ctl.mul2 = (state_q == ST_K_MUL2);
		mac_ctl.add  = (state_q == ST_K_ADD);
	end

	mco_mac u_mac (
		.clk    (clk),
		.ctl    (mac_ctl),
		.dim_i  (dim_i_q),
		.dim_k1 (dim_rd_q),
		.dim_j1 (dim_j1_q),
		.cost_a (a_diag_q ? '0 : cost_rd_a_q),
		.cost_b (b_diag_q ? '0 : cost_rd_b_q),
		.q      (mac_q)
	);

	// read addresses follow the sequencer step
	always_comb begin
		case (state_q)
			ST_CELL_B: dim_ra = j1_w;
			ST_K_RD:   dim_ra = k_q + IW'(1);
			default:   dim_ra = i_q;
		endcase
		case (state_q)
			ST_W_POP, ST_W_COST: cost_ra_a = cell_addr('0, m_q - IW'(1));
			default:             cost_ra_a = cell_addr(i_q, k_q);
		endcase
		cost_ra_b = cell_addr(k_q + IW'(1), j_w);
		cell_wa   = cell_addr(i_q, j_w);
		cell_we   = (state_q == ST_K_CMP) && (k_q + IW'(1) == j_w);
		split_ra  = cell_addr(stack_rd_q.lo, stack_rd_q.hi);
		if (state_q == ST_W_POP && sp_q != '0) begin
			stack_ra = STACK_AW'(sp_q - SP_W'(1));
		end else begin
			stack_ra = sp_q[STACK_AW-1:0];
		end
	end

	// stack pushes: root, then close mark, right half and left half of a split
	always_comb begin
		stack_we = 1'b0;
		stack_wd = '0;
		case (state_q)
			ST_W_ROOT: begin
				stack_we = 1'b1;
				stack_wd = '{close: 1'b0, lo: '0, hi: m_q - IW'(1)};
			end
			ST_W_SPLIT: begin
				stack_we = room;
				stack_wd = '{close: 1'b1, lo: '0, hi: '0};
			end
			ST_W_PUSH2: begin
				stack_we = 1'b1;
				stack_wd = '{close: 1'b0, lo: k_q + IW'(1), hi: w_j_q};
			end
			ST_W_PUSH3: begin
				stack_we = 1'b1;
				stack_wd = '{close: 1'b0, lo: w_i_q, hi: k_q};
			end
			default: begin
				stack_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (dim_accept && dim_room) begin
			dim_mem[dim_count_q[IW-1:0]] <= dimension;
		end
		dim_rd_q <= dim_mem[dim_ra];
	end

	always_ff @(posedge clk) begin
		if (cell_we) begin
			cost_mem[cell_wa]  <= best_nx;
			split_mem[cell_wa] <= bestk_nx;
		end
		cost_rd_a_q <= cost_mem[cost_ra_a];
		cost_rd_b_q <= cost_mem[cost_ra_b];
		split_rd_q  <= split_mem[split_ra];
	end

	always_ff @(posedge clk) begin
		if (stack_we) begin
			stack_mem[sp_q[STACK_AW-1:0]] <= stack_wd;
		end
		stack_rd_q <= stack_mem[stack_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dim_count_q <= '0;
			ovf_q       <= 1'b0;
			name_q      <= '0;
			sp_q        <= '0;
			tok_valid_q <= 1'b0;
		end else begin
			// drop the output item once taken, unless a new one is loaded below
			if (tok_valid_q && !tok_stall && !tok_load) begin
				tok_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (dim_accept) begin
						if (!final_dim) begin
							dim_count_q <= cnt_nx;
							ovf_q       <= ovf_nx;
						end else begin
							dim_count_q <= '0;
							ovf_q       <= 1'b0;
							m_q         <= m_nx;
							i_q         <= '0;
							len_q       <= IW'(2);
							if (ovf_nx || cnt_nx < CNT_W'(2)) begin
								state_q <= ST_ERR;
							end else if (m_nx == IW'(1)) begin
								state_q <= ST_W_ROOT;
							end else begin
								state_q <= ST_CELL_A;
							end
						end
					end
				end
				ST_ERR: begin
					if (out_free) begin
						tok_valid_q <= 1'b1;
						kind_q      <= TOK_ERROR;
						value_q     <= '0;
						end_q       <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_CELL_A: begin
					state_q <= ST_CELL_B;
				end
				ST_CELL_B: begin
					dim_i_q <= dim_rd_q;
					state_q <= ST_CELL_C;
				end
				ST_CELL_C: begin
					dim_j1_q <= dim_rd_q;
					k_q      <= i_q;
					state_q  <= ST_K_RD;
				end
				ST_K_RD: begin
					// diagonal cells cost nothing and are never stored
					a_diag_q <= (k_q == i_q);
					b_diag_q <= (k_q + IW'(1) == j_w);
					state_q  <= ST_K_MUL1;
				end
				ST_K_MUL1: begin
					state_q <= ST_K_MUL2;
				end
				ST_K_MUL2: begin
					state_q <= ST_K_ADD;
				end
				ST_K_ADD: begin
					state_q <= ST_K_CMP;
				end
				ST_K_CMP: begin
					best_q  <= best_nx;
					bestk_q <= bestk_nx;
					if (k_q + IW'(1) == j_w) begin
						if (j1_w < m_q) begin
							i_q     <= i_q + IW'(1);
							state_q <= ST_CELL_A;
						end else if (len_q < m_q) begin
							len_q   <= len_q + IW'(1);
							i_q     <= '0;
							state_q <= ST_CELL_A;
						end else begin
							state_q <= ST_W_ROOT;
						end
					end else begin
						k_q     <= k_q + IW'(1);
						state_q <= ST_K_RD;
					end
				end
				ST_W_ROOT: begin
					sp_q    <= SP_W'(1);
					state_q <= ST_W_POP;
				end
				ST_W_POP: begin
					if (sp_q == '0) begin
						state_q <= ST_W_COST;
					end else begin
						sp_q    <= sp_q - SP_W'(1);
						state_q <= ST_W_DEC;
					end
				end
				ST_W_DEC: begin
					if (out_free) begin
						tok_valid_q <= 1'b1;
						end_q       <= 1'b0;
						if (stack_rd_q.close) begin
							kind_q  <= TOK_CLOSE;
							value_q <= '0;
							state_q <= ST_W_POP;
						end else if (stack_rd_q.lo == stack_rd_q.hi) begin
							kind_q  <= TOK_NAME;
							value_q <= COST_W'(name_q);
							name_q  <= name_q + IW'(1);
							state_q <= ST_W_POP;
						end else begin
							kind_q  <= TOK_OPEN;
							value_q <= '0;
							w_i_q   <= stack_rd_q.lo;
							w_j_q   <= stack_rd_q.hi;
							state_q <= ST_W_SPLIT;
						end
					end
				end
				ST_W_SPLIT: begin
					k_q <= split_rd_q;
					if (room) begin
						sp_q    <= sp_q + SP_W'(1);
						state_q <= ST_W_PUSH2;
					end else begin
						state_q <= ST_W_POP;
					end
				end
				ST_W_PUSH2: begin
					sp_q    <= sp_q + SP_W'(1);
					state_q <= ST_W_PUSH3;
				end
				ST_W_PUSH3: begin
					sp_q    <= sp_q + SP_W'(1);
					state_q <= ST_W_POP;
				end
				ST_W_COST: begin
					if (out_free) begin
						tok_valid_q <= 1'b1;
						kind_q      <= TOK_COST;
						value_q     <= (m_q == IW'(1)) ? '0 : cost_rd_a_q;
						end_q       <= 1'b1;
						name_q      <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign tok_valid     = tok_valid_q;
	assign token_kind    = kind_q;
	assign token_value   = value_q;
	assign end_of_answer = end_q;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import mco_pkg::*;

	// Quiet-cycle budget: the longest silent stretch of a correct run is the cost fill of
	// a full 16-matrix chain or the long receiver hold-off below.
	localparam int QUIET_LIMIT   = 20000;
	localparam int TAIL_CYCLES   = 60;
	localparam int HOLD_CYCLES   = 500;
	localparam int TARGET_ITEMS  = 320;
	localparam int DIRECTED_N    = 24;
	localparam int NAME_WRAP     = 32;
	localparam logic [COST_W-1:0] COST_CAP = {COST_W{1'b1}};

	typedef enum int {
		PH_STEADY,
		PH_SENDER_IDLE,
		PH_RECEIVER_STALL,
		PH_BOTH_IDLE
	} phase_t;

	typedef struct {
		logic [DIM_W-1:0] dim;
		logic             fin;
		phase_t           phase;
		bit               drain;
	} dim_item_t;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [COST_W-1:0] value;
		logic              last;
	} token_t;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               dim_valid     = 1'b0;
	logic               dim_stall;
	logic [DIM_W-1:0]   dimension     = '0;
	logic               final_dim     = 1'b0;
	logic               tok_valid;
	logic               tok_stall     = 1'b0;
	logic [KIND_W-1:0]  token_kind;
	logic [COST_W-1:0]  token_value;
	logic               end_of_answer;

	// Directed chains: lone dimension (error), one matrix at the extremes, a textbook
	// three-matrix chain, equal dimensions (ties take the smallest split), zero
	// dimensions, full-scale dimensions, and a four-matrix chain with a deep split.
	logic [DIM_W-1:0] dir_dims [DIRECTED_N] = '{
		16'd65535,
		16'd0, 16'd65535,
		16'd10, 16'd30, 16'd5, 16'd60,
		16'd5, 16'd5, 16'd5, 16'd5,
		16'd0, 16'd7, 16'd0, 16'd3,
		16'd65535, 16'd65535, 16'd65535, 16'd65535,
		16'd40, 16'd20, 16'd30, 16'd10, 16'd30
	};
	bit dir_ends [DIRECTED_N] = '{
		1,
		0, 1,
		0, 0, 0, 1,
		0, 0, 0, 1,
		0, 0, 0, 1,
		0, 0, 0, 1,
		0, 0, 0, 0, 1
	};

	// Shadow state of the block
	logic [DIM_W-1:0]  chain_dims [DIM_DEPTH];
	int                chain_len   = 0;
	bit                chain_spill = 1'b0;
	logic [COST_W-1:0] cost_tab  [MAX_MATRICES][MAX_MATRICES];
	int                split_tab [MAX_MATRICES][MAX_MATRICES];
	int                next_name   = 0;

	token_t    answer_q [$];
	dim_item_t pending  [$];

	phase_t idle_phase   = PH_STEADY;
	int     failures     = 0;
	int     items_in     = 0;
	int     chains_done  = 0;
	int     error_chains = 0;
	int     tokens_seen  = 0;
	int     answers_seen = 0;
	int     hold_left    = 0;
	bit     hold_done    = 1'b0;
	int     quiet        = 0;

	matrix_chain_order_dp i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.dim_valid     (dim_valid),
		.dim_stall     (dim_stall),
		.dimension     (dimension),
		.final_dim     (final_dim),
		.tok_valid     (tok_valid),
		.tok_stall     (tok_stall),
		.token_kind    (token_kind),
		.token_value   (token_value),
		.end_of_answer (end_of_answer)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ---------------------------------------------------------------- cost predictor

	// Saturating 52-bit sum, worked in 64 bits.
	function automatic logic [COST_W-1:0] cap_sum(input logic [COST_W-1:0] a,
		input logic [COST_W-1:0] b);
		longint unsigned s;
		s = longint'(a) + longint'(b);
		return (s > longint'(COST_CAP)) ? COST_CAP : COST_W'(s);
	endfunction

	function automatic void push_token(input logic [KIND_W-1:0] kind,
		input logic [COST_W-1:0] value, input logic last);
		token_t t;
		t.kind  = kind;
		t.value = value;
		t.last  = last;
		answer_q.push_back(t);
	endfunction

	// Emit the bracketing of matrices lo..hi: a name for a single matrix, otherwise
	// open, left part, right part, close - the same order as the block's stack walk.
	function automatic void emit_tree(input int lo, input int hi);
		int k;
		if (lo == hi) begin
			push_token(TOK_NAME, COST_W'(next_name), 1'b0);
			next_name = (next_name + 1) % NAME_WRAP;
		end else begin
			k = split_tab[lo][hi];
			push_token(TOK_OPEN, '0, 1'b0);
			emit_tree(lo, k);
			emit_tree(k + 1, hi);
			push_token(TOK_CLOSE, '0, 1'b0);
		end
	endfunction

	// Take one accepted dimension; on the last of a chain, solve it and queue its answer.
	function automatic void absorb_dimension(input logic [DIM_W-1:0] d, input logic fin);
		int                nmat;
		int                span;
		int                lo;
		int                hi;
		int                k;
		logic [COST_W-1:0] best;
		logic [COST_W-1:0] trial;
		logic [COST_W-1:0] prod;
		if (chain_len < DIM_DEPTH) begin
			chain_dims[chain_len] = d;
			chain_len++;
		end else begin
			chain_spill = 1'b1;
		end
		if (fin) begin
			if (chain_spill || chain_len < 2) begin
				push_token(TOK_ERROR, '0, 1'b1);
				error_chains++;
			end else begin
				nmat = chain_len - 1;
				for (lo = 0; lo < nmat; lo++)
					cost_tab[lo][lo] = '0;
				for (span = 2; span <= nmat; span++) begin
					for (lo = 0; lo + span <= nmat; lo++) begin
						hi   = lo + span - 1;
						best = '0;
						for (k = lo; k < hi; k++) begin
							prod  = COST_W'(chain_dims[lo]) * COST_W'(chain_dims[k + 1]) *
								COST_W'(chain_dims[hi + 1]);
							trial = cap_sum(cap_sum(cost_tab[lo][k], cost_tab[k + 1][hi]), prod);
							// strict compare keeps the smallest split on a tie
							if (k == lo || trial < best) begin
								best            = trial;
								split_tab[lo][hi] = k;
							end
						end
						cost_tab[lo][hi] = best;
					end
				end
				next_name = 0;
				emit_tree(0, nmat - 1);
				push_token(TOK_COST, cost_tab[0][nmat - 1], 1'b1);
			end
			chain_len   = 0;
			chain_spill = 1'b0;
			next_name   = 0;
			chains_done++;
		end
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic int idle_pct(input phase_t phase, input bit sender);
		case (phase)
			PH_SENDER_IDLE:    return sender ? 81 : 0;
			PH_RECEIVER_STALL: return sender ? 0 : 81;
			PH_BOTH_IDLE:      return 31;
			default:           return 0;
		endcase
	endfunction

	// Small values most often, with zero, one, full scale and the whole range mixed in.
	function automatic logic [DIM_W-1:0] pick_dim();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			return DIM_W'($urandom_range(64, 1));
		else if (r < 50)
			return '0;
		else if (r < 55)
			return '1;
		else if (r < 58)
			return DIM_W'(1);
		else
			return DIM_W'($urandom);
	endfunction

	function automatic void enqueue_dim(input logic [DIM_W-1:0] d, input logic fin,
		input phase_t phase, input bit drain);
		dim_item_t it;
		it.dim   = d;
		it.fin   = fin;
		it.phase = phase;
		it.drain = drain;
		pending.push_back(it);
	endfunction

	// ---------------------------------------------------------------- driver

	// Offer the next pending item, with random idling by phase, whenever the current one has gone (or none is up).
	// An item marked for draining is held back until every queued token has arrived.
	always @(posedge clk or negedge arst_n) begin : drive_dims
		dim_item_t nxt;
		logic      go;
		if (!arst_n) begin
			dim_valid <= 1'b0;
		end else if (!(dim_valid && dim_stall)) begin
			if (dim_valid) begin
				absorb_dimension(dimension, final_dim);
				items_in++;
			end
			go = 1'b0;
			if (pending.size() > 0) begin
				nxt = pending[0];
				go  = !(nxt.drain && answer_q.size() != 0) &&
					($urandom_range(99) >= idle_pct(nxt.phase, 1'b1));
			end
			if (go) begin
				pending.delete(0);
				dimension  <= nxt.dim;
				final_dim  <= nxt.fin;
				idle_phase <= nxt.phase;
			end
			dim_valid <= go;
		end
	end

	// ---------------------------------------------------------------- monitor

	// Check each accepted token against the oldest expectation, then pick the stall
	// for the next cycle. Once, well into the run, hold off for a long stretch while
	// items are still waiting, so the block backs up and stalls its input.
	always @(posedge clk or negedge arst_n) begin : watch_tokens
		token_t want;
		logic   hold_now;
		if (!arst_n) begin
			tok_stall <= 1'b0;
		end else begin
			if (tok_valid && !tok_stall) begin
				tokens_seen++;
				if (end_of_answer)
					answers_seen++;
				if (answer_q.size() == 0) begin
					$error("unexpected token: kind %0d value %0d end %0d",
						token_kind, token_value, end_of_answer);
					failures++;
				end else begin
					want = answer_q[0];
					answer_q.delete(0);
					if (token_kind !== want.kind) begin
						$error("token_kind: expected %0d, actual %0d", want.kind, token_kind);
						failures++;
					end
					if (token_value !== want.value) begin
						$error("token_value: expected %0d, actual %0d", want.value, token_value);
						failures++;
					end
					if (end_of_answer !== want.last) begin
						$error("end_of_answer: expected %0d, actual %0d", want.last,
							end_of_answer);
						failures++;
					end
				end
				if (!hold_done && answers_seen >= 8 && pending.size() > 0) begin
					hold_left = HOLD_CYCLES;
					hold_done = 1'b1;
				end
			end
			if (hold_left > 0) begin
				hold_now = 1'b1;
				hold_left--;
			end else begin
				hold_now = ($urandom_range(99) < idle_pct(idle_phase, 1'b0));
			end
			tok_stall <= hold_now;
		end
	end

	// ---------------------------------------------------------------- watchdog

	// Count cycles with no handshake on either side; give up at the limit.
	always @(posedge clk) begin : watchdog
		if (!arst_n || (dim_valid && !dim_stall) || (tok_valid && !tok_stall)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin : run_test
		int     generated;
		int     chain_no;
		int     len;
		int     n;
		int     r;
		phase_t phase;
		phase_t last_phase;

		// Directed chains first, without idling
		for (n = 0; n < DIRECTED_N; n++)
			enqueue_dim(dir_dims[n], dir_ends[n], PH_STEADY, 1'b0);

		// Random chains: mostly well-formed with random dimensions, the rest lone
		// dimensions and over-long chains. Advance the idling phase by item count and
		// drain the block at the start of each phase.
		generated  = 0;
		chain_no   = 0;
		last_phase = PH_STEADY;
		while (generated < TARGET_ITEMS) begin
			phase = phase_t'(generated * 4 / TARGET_ITEMS);
			if (chain_no == 0) begin
				len = DIM_DEPTH;
			end else if (chain_no == 1) begin
				len = DIM_DEPTH + 2;
			end else begin
				r = $urandom_range(99);
				if (r < 8)
					len = 1;
				else if (r < 16)
					len = $urandom_range(DIM_DEPTH + 3, DIM_DEPTH + 1);
				else if (r < 24)
					len = DIM_DEPTH;
				else
					len = $urandom_range(DIM_DEPTH - 1, 2);
			end
			for (n = 0; n < len; n++)
				enqueue_dim(pick_dim(), n == len - 1, phase,
					n == 0 && (chain_no == 0 || phase != last_phase));
			last_phase = phase;
			generated += len;
			chain_no++;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the last item to go and every token to come back
		while (pending.size() != 0 || dim_valid || answer_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d dimension items in %0d chains, %0d of them ending in an error token.",
			items_in, chains_done, error_chains);
		$display("Checked %0d tokens over %0d answers across four idling phases and a long hold-off.",
			tokens_seen, answers_seen);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

/* matrix_chain_order_dp.f */
src/mco_pkg.sv
src/mco_mac.sv
src/matrix_chain_order_dp.sv
tb/sv/tb_top.sv
